@@ src/dcbc_pkg.sv @@
`timescale 1ns / 1ps

package dcbc_pkg;

	// default sizes
	localparam int TABLE_BITS_DEF  = 17;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int TOTAL_W         = 48;
	localparam int HASH_W          = 17;
	localparam int RESULT_CNT_W    = 32;

	// register map (index = paddr[2])
	localparam logic REG_HASH_MODE = 1'b0;
	localparam logic REG_ALPHABET  = 1'b1;

	// hash modes
	localparam logic [2:0] HM_BE     = 3'd0;
	localparam logic [2:0] HM_GOLD   = 3'd1;
	localparam logic [2:0] HM_CRC16  = 3'd2;
	localparam logic [2:0] HM_CRC15  = 3'd3;
	localparam logic [2:0] HM_MULADD = 3'd4;

	// alphabets
	localparam logic [1:0] AL_ALNUM = 2'd0;
	localparam logic [1:0] AL_PRINT = 2'd1;
	localparam logic [1:0] AL_ASCII = 2'd2;
	localparam logic [1:0] AL_ALL   = 2'd3;

	// multiplier constants
	localparam logic [31:0] K_BE     = 32'd506832829;
	localparam logic [31:0] K_GOLD   = 32'd2654435761;
	localparam logic [31:0] K_MULADD = 32'd66521;

	localparam logic [31:0] CRC_POLY = 32'h82F63B78;

	// command from sequencer to datapath
	typedef struct packed {
		logic clear;
		logic load_in;
		logic do_mul;
		logic do_hash;
		logic do_rd;
		logic do_upd;
	} cmd_t;

	// status from datapath to sequencer
	typedef struct packed {
		logic clr_last;
	} sts_t;

	// CRC32C of a 32-bit word with zero init is linear: one column per input bit.
	// Evaluated at elaboration only.
	function automatic logic [31:0][31:0] crc_cols();
		logic [31:0][31:0] c;
		logic [31:0]       r;
		for (int i = 0; i < 32; i++) begin
			r = 32'(1) << i;
			for (int j = 0; j < 32; j++) begin
				r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
			end
			c[i] = r;
		end
		return c;
	endfunction

	localparam logic [31:0][31:0] CRC_COLS = crc_cols();

	function automatic logic [31:0] crc_word(input logic [31:0] v);
		logic [31:0] r;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				r = r ^ CRC_COLS[i];
			end
		end
		return r;
	endfunction

endpackage

@@ src/dcbc_ram.sv @@
`timescale 1ns / 1ps

module dcbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/dcbc_ctrl.sv @@
`timescale 1ns / 1ps

module dcbc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cand_valid,
	output logic          cand_stall,
	output logic          res_valid,
	input  logic          res_stall,
	input  dcbc_pkg::sts_t sts,
	output dcbc_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_MUL  = 6'b000100,
		S_HASH = 6'b001000,
		S_RD   = 6'b010000,
		S_UPD  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   accept;
	logic   slot_free;

	assign cand_stall = (state_q != S_IDLE);
	assign accept     = cand_valid && !cand_stall;
	// result register empty now or emptied at this edge
	assign slot_free  = !res_valid_q || !res_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR:  if (sts.clr_last) state_d = S_IDLE;
			S_IDLE: if (accept) state_d = S_MUL;
			S_MUL:  state_d = S_HASH;
			S_HASH: state_d = S_RD;
			S_RD:   if (slot_free) state_d = S_UPD;
			S_UPD:  state_d = S_IDLE;
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_UPD) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign cmd.clear   = (state_q == S_CLR);
	assign cmd.load_in = accept;
	assign cmd.do_mul  = (state_q == S_MUL);
	assign cmd.do_hash = (state_q == S_HASH);
	assign cmd.do_rd   = (state_q == S_RD);
	assign cmd.do_upd  = (state_q == S_UPD);

endmodule

@@ src/dcbc_dp.sv @@
`timescale 1ns / 1ps

module dcbc_dp #(
	parameter int TABLE_BITS  = dcbc_pkg::TABLE_BITS_DEF,
	parameter int COUNT_WIDTH = dcbc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dcbc_pkg::cmd_t                       cmd,
	output dcbc_pkg::sts_t                       sts,
	input  logic [2:0]                           hash_mode,
	input  logic [1:0]                           alphabet,
	input  logic [31:0]                          first_four_bytes,
	input  logic [7:0]                           fifth_byte,
	output logic                                 in_alphabet,
	output logic                                 collided,
	output logic [dcbc_pkg::HASH_W-1:0]          hash_value,
	output logic [dcbc_pkg::RESULT_CNT_W-1:0]    bucket_count,
	output logic                                 first_differs,
	output logic [dcbc_pkg::TOTAL_W-1:0]         total_collisions
);

	// stored count never exceeds 32 bits
	localparam int CW    = (COUNT_WIDTH > dcbc_pkg::RESULT_CNT_W) ?
		dcbc_pkg::RESULT_CNT_W : COUNT_WIDTH;
	localparam int DEPTH = 1 << TABLE_BITS;

	function automatic logic byte_ok(input logic [1:0] al, input logic [7:0] b);
		logic r;
		case (al)
			dcbc_pkg::AL_ALNUM: r = b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
			dcbc_pkg::AL_PRINT: r = b inside {[8'h20:8'h7E]};
			dcbc_pkg::AL_ASCII: r = !b[7];
			default:            r = 1'b1;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] bswap(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	// multiplier operand and constant for one window
	function automatic logic [63:0] mul_sel(input logic [2:0] m, input logic [31:0] v);
		logic [63:0] r;
		case (m)
			dcbc_pkg::HM_GOLD:   r = {v, dcbc_pkg::K_GOLD};
			dcbc_pkg::HM_MULADD: r = {v, dcbc_pkg::K_MULADD};
			default:             r = {bswap(v), dcbc_pkg::K_BE};
		endcase
		return r;
	endfunction

	// final hash from registered product and crc
	function automatic logic [dcbc_pkg::HASH_W-1:0] hash_post(input logic [2:0] m,
			input logic [31:0] p, input logic [31:0] c);
		logic [dcbc_pkg::HASH_W-1:0] r;
		logic [31:0]                 s;
		s = p + dcbc_pkg::K_MULADD;
		case (m)
			dcbc_pkg::HM_GOLD:   r = {1'b0, p[31:16]};
			dcbc_pkg::HM_CRC16:  r = {1'b0, c[15:0]};
			dcbc_pkg::HM_CRC15:  r = {2'b00, c[14:0]};
			dcbc_pkg::HM_MULADD: r = {2'b00, s[30:16]};
			default:             r = p[31:15];
		endcase
		return r;
	endfunction

	logic [31:0]      x_q;
	logic [7:0]       e_q;
	logic [31:0]      y;
	logic [63:0]      opx, opy;
	logic [31:0]      prod_x_q, prod_y_q, crc_x_q, crc_y_q;
	logic             ok_q;
	logic [dcbc_pkg::HASH_W-1:0] hx, hy, hx_q;
	logic             coll_q;
	logic [TABLE_BITS-1:0] clr_q;
	logic [TABLE_BITS-1:0] idx;
	logic [CW:0]      cnt_rdata;
	logic [7:0]       fb_rdata;
	logic [CW-1:0]    cnt_rd, cnt_new, cnt_sel;
	logic             diff_rd, diff_new, diff_sel, cnt_zero;
	logic             cnt_we, fb_we;
	logic [TABLE_BITS-1:0] cnt_waddr;
	logic [CW:0]      cnt_wdata;
	logic [dcbc_pkg::TOTAL_W-1:0] total_q;
	logic             oa_q, oc_q, odiff_q;
	logic [dcbc_pkg::HASH_W-1:0] oh_q;
	logic [dcbc_pkg::RESULT_CNT_W-1:0] ocnt_q;

	assign y   = {e_q, x_q[31:8]};
	assign opx = mul_sel(hash_mode, x_q);
	assign opy = mul_sel(hash_mode, y);

	// input latch and multiply stage
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q <= first_four_bytes;
			e_q <= fifth_byte;
		end
		if (cmd.do_mul) begin
			prod_x_q <= opx[63:32] * opx[31:0];
			prod_y_q <= opy[63:32] * opy[31:0];
			crc_x_q  <= dcbc_pkg::crc_word(x_q);
			crc_y_q  <= dcbc_pkg::crc_word(y);
			ok_q     <= byte_ok(alphabet, x_q[7:0]) && byte_ok(alphabet, x_q[15:8]) &&
				byte_ok(alphabet, x_q[23:16]) && byte_ok(alphabet, x_q[31:24]) &&
				byte_ok(alphabet, e_q);
		end
	end

	assign hx = hash_post(hash_mode, prod_x_q, crc_x_q);
	assign hy = hash_post(hash_mode, prod_y_q, crc_y_q);

	always_ff @(posedge clk) begin
		if (cmd.do_hash) begin
			hx_q   <= hx;
			coll_q <= ok_q && (hx == hy);
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign sts.clr_last = &clr_q;

	assign idx = hx_q[TABLE_BITS-1:0];

	// bucket read-modify-write
	assign cnt_rd   = cnt_rdata[CW-1:0];
	assign diff_rd  = cnt_rdata[CW];
	assign cnt_zero = (cnt_rd == '0);
	assign cnt_new  = (&cnt_rd) ? cnt_rd : cnt_rd + CW'(1);
	assign diff_new = diff_rd || (!cnt_zero && (fb_rdata != x_q[7:0]));
	assign cnt_sel  = coll_q ? cnt_new : cnt_rd;
	assign diff_sel = coll_q ? diff_new : diff_rd;

	assign cnt_we    = cmd.clear || (cmd.do_upd && coll_q);
	assign cnt_waddr = cmd.clear ? clr_q : idx;
	assign cnt_wdata = cmd.clear ? '0 : {diff_new, cnt_new};
	assign fb_we     = cmd.do_upd && coll_q && cnt_zero;

	dcbc_ram #(
		.WIDTH(CW + 1),
		.DEPTH(DEPTH)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.re   (cmd.do_rd),
		.raddr(idx),
		.rdata(cnt_rdata)
	);

	dcbc_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_fb_ram (
		.clk  (clk),
		.we   (fb_we),
		.waddr(idx),
		.wdata(x_q[7:0]),
		.re   (cmd.do_rd),
		.raddr(idx),
		.rdata(fb_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.do_upd && coll_q && !(&total_q)) begin
			total_q <= total_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.do_upd) begin
			oa_q    <= ok_q;
			oc_q    <= coll_q;
			oh_q    <= hx_q;
			ocnt_q  <= dcbc_pkg::RESULT_CNT_W'(cnt_sel);
			odiff_q <= diff_sel;
		end
	end

	assign in_alphabet      = oa_q;
	assign collided         = oc_q;
	assign hash_value       = oh_q;
	assign bucket_count     = ocnt_q;
	assign first_differs    = odiff_q;
	assign total_collisions = total_q;

endmodule

@@ src/double_collision_bucket_counter_core.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// cand      in         cand_valid/cand_stall   first_four_bytes, fifth_byte
// res       out        res_valid/res_stall     in_alphabet, collided, hash_value,
//                                              bucket_count, first_differs,
//                                              total_collisions
// cfg       in         APB, pready tied high   hash_mode @0x0, alphabet @0x4
//
// Steps: a candidate transfer is followed by multiply, hash, bucket read and
// bucket update steps; the result is registered at the end of the update step,
// and the next candidate is taken only after the sequencer returns to idle. The
// sequencer's step order sets this; a stalled res holds it in the read step.
// Reset: after arst_n releases, a clearing sweep zeroes the count/flag RAM, one
// entry per cycle over all 2^TABLE_BITS entries; cand_stall stays high meanwhile.
// Config writes are taken at any time. A stalled result holds; the bucket update
// waits until the result register is free.

module double_collision_bucket_counter_core #(
	parameter int TABLE_BITS  = dcbc_pkg::TABLE_BITS_DEF,
	parameter int COUNT_WIDTH = dcbc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// candidate channel
	input  logic                              cand_valid,
	output logic                              cand_stall,
	input  logic [31:0]                       first_four_bytes,
	input  logic [7:0]                        fifth_byte,
	// result channel
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic                              in_alphabet,
	output logic                              collided,
	output logic [dcbc_pkg::HASH_W-1:0]       hash_value,
	output logic [dcbc_pkg::RESULT_CNT_W-1:0] bucket_count,
	output logic                              first_differs,
	output logic [dcbc_pkg::TOTAL_W-1:0]      total_collisions
);

	logic [2:0]     hash_mode_q;
	logic [1:0]     alphabet_q;
	logic           cfg_wr;
	dcbc_pkg::cmd_t cmd;
	dcbc_pkg::sts_t sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// register decode uses the word index only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mode_q <= dcbc_pkg::HM_BE;
			alphabet_q  <= dcbc_pkg::AL_ALNUM;
		end else if (cfg_wr) begin
			case (paddr[2])
				dcbc_pkg::REG_HASH_MODE: hash_mode_q <= pwdata[2:0];
				dcbc_pkg::REG_ALPHABET:  alphabet_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			dcbc_pkg::REG_HASH_MODE: prdata = {29'd0, hash_mode_q};
			dcbc_pkg::REG_ALPHABET:  prdata = {30'd0, alphabet_q};
			default:                 prdata = '0;
		endcase
	end

	// sequencer: clear sweep, then one candidate at a time
	dcbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cand_valid(cand_valid),
		.cand_stall(cand_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// hashing, bucket RAMs, counters and result register
	dcbc_dp #(
		.TABLE_BITS (TABLE_BITS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.hash_mode       (hash_mode_q),
		.alphabet        (alphabet_q),
		.first_four_bytes(first_four_bytes),
		.fifth_byte      (fifth_byte),
		.in_alphabet     (in_alphabet),
		.collided        (collided),
		.hash_value      (hash_value),
		.bucket_count    (bucket_count),
		.first_differs   (first_differs),
		.total_collisions(total_collisions)
	);

endmodule

@@ src/dcbc_checker.sv @@
`timescale 1ns / 1ps

module dcbc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cand_valid,
	input logic                              cand_stall,
	input logic                              res_valid,
	input logic                              res_stall,
	input logic                              in_alphabet,
	input logic                              collided,
	input logic [dcbc_pkg::HASH_W-1:0]       hash_value,
	input logic [dcbc_pkg::RESULT_CNT_W-1:0] bucket_count,
	input logic [dcbc_pkg::TOTAL_W-1:0]      total_collisions
);

	// one candidate in flight: stall rises right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(cand_valid && !cand_stall) |=> cand_stall)
		else $error("candidate taken while previous one in flight");

	a_coll_needs_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && collided) |-> in_alphabet)
		else $error("collision reported outside alphabet");

	a_coll_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && collided) |-> ((bucket_count != '0) && (total_collisions != '0)))
		else $error("collision with zero counter");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(hash_value) &&
			$stable(bucket_count)))
		else $error("stalled result changed");

endmodule

bind double_collision_bucket_counter_core dcbc_checker u_dcbc_checker (.*);
